[design/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[design/tlvx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tlvx_pkg;

  // parse phases
  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_HDR2  = 3'd2;
  localparam logic [2:0] PH_HDR3  = 3'd3;
  localparam logic [2:0] PH_VALUE = 3'd4;
  localparam logic [2:0] PH_IDLE  = 3'd5;

  // parse_status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_VAL_TRUNC = 2'd1;
  localparam logic [1:0] ST_HDR_TRUNC = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_RECORDS = 2'd0;
  localparam logic [1:0] CFG_MATCH_TYPE  = 2'd1;
  localparam logic [1:0] CFG_MATCH_INDEX = 2'd2;

  localparam logic [7:0]  MAX_RECORDS_RST = 8'd0;
  localparam logic [15:0] MATCH_TYPE_RST  = 16'd0;
  localparam logic [15:0] MATCH_INDEX_RST = 16'd1;

  typedef struct packed {
    logic [15:0] record_type;
    logic [15:0] record_length;
    logic        is_match;
    logic [31:0] value_dword;
    logic [15:0] value_word;
    logic [7:0]  value_byte;
    logic [1:0]  parse_status;
    logic        end_of_chain;
  } tlvx_result_t;

endpackage

`default_nettype wire

[design/tlv_stream_parser_extract_top.sv]
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_valid/in_stall  | data_byte, first_of_buffer, last_of_buffer
// out_    | out | out_valid/out_stall| type, length, match, value words, status, eoc
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index (2b), cfg_data (16b)
//
// One byte is accepted per cycle unless in_stall; its result (if any) is registered.
// The parse step is one pass of logic from the state registers to the result register.
// A two-entry output (result register plus skid register) keeps in_stall registered;
// in_stall rises only once both entries hold results and drops as the output drains.
// rst_n is synchronous: parse state, counters and config registers take reset values.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tlv_stream_parser_extract_top (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_of_buffer,
  input  wire logic        in_last_of_buffer,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_record_type,
  output logic [15:0]      out_record_length,
  output logic             out_is_match,
  output logic [31:0]      out_value_dword,
  output logic [15:0]      out_value_word,
  output logic [7:0]       out_value_byte,
  output logic [1:0]       out_parse_status,
  output logic             out_end_of_chain,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // config
  logic [7:0]  max_records_r;
  logic [15:0] match_type_r;
  logic [15:0] match_index_r;

  // parse state
  logic [2:0]  phase_r,        phase_nxt;
  logic [15:0] type_r,         type_nxt;
  logic [15:0] length_r,       length_nxt;
  logic [15:0] bytes_left_r,   bytes_left_nxt;
  logic [31:0] head_r,         head_nxt;
  logic [7:0]  records_done_r, records_done_nxt;
  logic [15:0] matches_seen_r, matches_seen_nxt;

  // output stage
  logic                  out_valid_r;
  logic                  skid_valid_r;
  tlvx_pkg::tlvx_result_t out_r;
  tlvx_pkg::tlvx_result_t skid_r;

  tlvx_pkg::tlvx_result_t res;
  logic        res_valid;
  logic        complete;
  logic        end_hit;
  logic [15:0] val_idx;
  logic        in_fire;
  logic        out_take;
  logic        res_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign res_fire  = in_fire && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_records_r <= tlvx_pkg::MAX_RECORDS_RST;
      match_type_r  <= tlvx_pkg::MATCH_TYPE_RST;
      match_index_r <= tlvx_pkg::MATCH_INDEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlvx_pkg::CFG_MAX_RECORDS: max_records_r <= cfg_data[7:0];
        tlvx_pkg::CFG_MATCH_TYPE:  match_type_r  <= cfg_data;
        tlvx_pkg::CFG_MATCH_INDEX: match_index_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // one parse step for the byte on the input
  always_comb begin
    if (in_first_of_buffer) begin
      phase_nxt        = tlvx_pkg::PH_HDR0;
      type_nxt         = '0;
      length_nxt       = '0;
      bytes_left_nxt   = '0;
      head_nxt         = '0;
      records_done_nxt = '0;
      matches_seen_nxt = '0;
    end else begin
      phase_nxt        = phase_r;
      type_nxt         = type_r;
      length_nxt       = length_r;
      bytes_left_nxt   = bytes_left_r;
      head_nxt         = head_r;
      records_done_nxt = records_done_r;
      matches_seen_nxt = matches_seen_r;
    end
    complete  = 1'b0;
    end_hit   = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    val_idx   = length_nxt - bytes_left_nxt;

    if (phase_nxt < tlvx_pkg::PH_IDLE) begin
      case (phase_nxt)
        tlvx_pkg::PH_HDR0: begin
          type_nxt  = {in_data_byte, 8'h00};
          head_nxt  = '0;
          phase_nxt = tlvx_pkg::PH_HDR1;
        end
        tlvx_pkg::PH_HDR1: begin
          type_nxt  = {type_nxt[15:8], in_data_byte};
          phase_nxt = tlvx_pkg::PH_HDR2;
        end
        tlvx_pkg::PH_HDR2: begin
          length_nxt = {in_data_byte, 8'h00};
          phase_nxt  = tlvx_pkg::PH_HDR3;
        end
        tlvx_pkg::PH_HDR3: begin
          length_nxt     = {length_nxt[15:8], in_data_byte};
          bytes_left_nxt = length_nxt;
          if (length_nxt == 16'd0) begin
            complete = 1'b1;
          end else begin
            phase_nxt = tlvx_pkg::PH_VALUE;
          end
        end
        default: begin
          // value byte: only the first four land in the head word
          if (val_idx[15:2] == 14'd0) begin
            case (val_idx[1:0])
              2'd0:    head_nxt[31:24] = in_data_byte;
              2'd1:    head_nxt[23:16] = in_data_byte;
              2'd2:    head_nxt[15:8]  = in_data_byte;
              default: head_nxt[7:0]   = in_data_byte;
            endcase
          end
          bytes_left_nxt = bytes_left_nxt - 16'd1;
          complete       = (bytes_left_nxt == 16'd0);
        end
      endcase

      if (complete) begin
        if (records_done_nxt != 8'hFF) begin
          records_done_nxt = records_done_nxt + 8'd1;
        end
        if (type_nxt == match_type_r) begin
          if (matches_seen_nxt != 16'hFFFF) begin
            matches_seen_nxt = matches_seen_nxt + 16'd1;
          end
          res.is_match = (match_index_r != 16'd0) && (matches_seen_nxt == match_index_r);
        end
        end_hit = in_last_of_buffer ||
                  ((max_records_r != 8'd0) && (records_done_nxt == max_records_r));
        res.record_type   = type_nxt;
        res.record_length = length_nxt;
        res.value_dword   = (length_nxt >= 16'd4) ? head_nxt : 32'd0;
        res.value_word    = (length_nxt >= 16'd2) ? head_nxt[31:16] : 16'd0;
        res.value_byte    = (length_nxt >= 16'd1) ? head_nxt[31:24] : 8'd0;
        res.parse_status  = tlvx_pkg::ST_OK;
        res.end_of_chain  = end_hit;
        res_valid         = 1'b1;
        phase_nxt         = end_hit ? tlvx_pkg::PH_IDLE : tlvx_pkg::PH_HDR0;
      end else if (in_last_of_buffer) begin
        res.parse_status = (phase_nxt == tlvx_pkg::PH_VALUE) ?
                           tlvx_pkg::ST_VAL_TRUNC : tlvx_pkg::ST_HDR_TRUNC;
        res.end_of_chain = 1'b1;
        res_valid        = 1'b1;
        phase_nxt        = tlvx_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= tlvx_pkg::PH_HDR0;
      type_r         <= '0;
      length_r       <= '0;
      bytes_left_r   <= '0;
      head_r         <= '0;
      records_done_r <= '0;
      matches_seen_r <= '0;
    end else if (in_fire) begin
      phase_r        <= phase_nxt;
      type_r         <= type_nxt;
      length_r       <= length_nxt;
      bytes_left_r   <= bytes_left_nxt;
      head_r         <= head_nxt;
      records_done_r <= records_done_nxt;
      matches_seen_r <= matches_seen_nxt;
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (res_fire) begin
      if (!out_valid_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_record_type   = out_r.record_type;
  assign out_record_length = out_r.record_length;
  assign out_is_match      = out_r.is_match;
  assign out_value_dword   = out_r.value_dword;
  assign out_value_word    = out_r.value_word;
  assign out_value_byte    = out_r.value_byte;
  assign out_parse_status  = out_r.parse_status;
  assign out_end_of_chain  = out_r.end_of_chain;

  `ASSERT_PROP(a_skid_needs_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `ASSERT_PROP(a_skid_drains_to_out, clk, rst_n, (skid_valid_r && !out_stall) |=> out_valid_r)
  `ASSERT_NEVER(a_phase_range, clk, rst_n, phase_r > tlvx_pkg::PH_IDLE)
  `ASSERT_PROP(a_value_left, clk, rst_n, (phase_r == tlvx_pkg::PH_VALUE) |-> (bytes_left_r != 16'd0))

endmodule

`default_nettype wire
